// ===== src/foc_current_loop_unit_defines.svh =====
// assertion macros used by the checker file
`ifndef FOC_CURRENT_LOOP_UNIT_DEFINES_SVH
`define FOC_CURRENT_LOOP_UNIT_DEFINES_SVH

// same-cycle implication, sampled on clk and dropped while reset is low
`define FCLU_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define FCLU_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== src/fclu_pkg.sv =====
// ---------------------------------------------------------------------------
// fclu_pkg
// Types, constants and the sine table of the FOC current loop unit.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package fclu_pkg;

	localparam int SINE_TABLE_DEPTH = 1024;
	localparam int SINE_IDX_W = $clog2(SINE_TABLE_DEPTH);
	localparam int SINE_QUARTER = SINE_TABLE_DEPTH / 4;

	localparam longint COEF_A1 = 64'sd1686629713;
	localparam longint COEF_A3 = -64'sd693598668;
	localparam longint COEF_A5 = 64'sd85569306;
	localparam longint COEF_A7 = -64'sd5026995;
	localparam longint COEF_A9 = 64'sd172272;

	localparam logic signed [17:0] INV_SQRT3_Q16 = 18'sd37837;

	// serial multiplier: 18 bit operands, 4 bit digits, 5 digit steps
	localparam int MUL_W = 18;
	localparam int DIGIT_W = 4;
	localparam int MUL_DIGITS = 5;
	localparam int PROD_W = 2 * MUL_W;
	localparam int ACC_W = 40;

	localparam int PADDR_W = 4;

	typedef logic signed [15:0] sine_rom_t [SINE_TABLE_DEPTH];

	typedef struct packed {
		logic signed [15:0] current_a;
		logic signed [15:0] current_b;
		logic        [15:0] angle;
		logic signed [15:0] target_d;
		logic signed [15:0] target_q;
	} sample_t;

	typedef struct packed {
		logic signed [15:0] volt_alpha;
		logic signed [15:0] volt_beta;
	} volt_t;

	typedef enum logic [1:0] {
		REG_PROP_GAIN  = 2'd0,
		REG_INTEG_GAIN = 2'd1,
		REG_LIMIT      = 2'd2
	} reg_idx_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ROM_SIN,
		ST_ROM_COS,
		ST_ROM_LAST,
		ST_MUL_START,
		ST_MUL_WAIT,
		ST_FIN,
		ST_OUT
	} state_t;

	typedef enum logic [3:0] {
		OP_BETA   = 4'd0,
		OP_ID_C   = 4'd1,
		OP_ID_S   = 4'd2,
		OP_IQ_C   = 4'd3,
		OP_IQ_S   = 4'd4,
		OP_INTD   = 4'd5,
		OP_VD     = 4'd6,
		OP_INTQ   = 4'd7,
		OP_VQ     = 4'd8,
		OP_VA_C   = 4'd9,
		OP_VA_S   = 4'd10,
		OP_VB_S   = 4'd11,
		OP_VB_C   = 4'd12
	} op_t;

	typedef enum logic [1:0] {
		ACC_LOAD,
		ACC_ADD,
		ACC_SUB
	} acc_mode_t;

	typedef enum logic [3:0] {
		FIN_NONE,
		FIN_BETA,
		FIN_ID,
		FIN_IQ,
		FIN_INTD,
		FIN_VD,
		FIN_INTQ,
		FIN_VQ,
		FIN_VA,
		FIN_VB
	} fin_t;

	function automatic longint rnd_asr(longint x, int s);
		return (x + (longint'(1) <<< (s - 1))) >>> s;
	endfunction

	function automatic logic signed [15:0] sine_entry(int k);
		longint p;
		longint quad;
		longint r;
		longint u;
		longint x;
		longint x2;
		longint acc;
		longint mag;
		p = ((longint'(k) * 64'sd65536) / SINE_TABLE_DEPTH) & 64'sd65535;
		quad = p >>> 14;
		r = p & 64'sd16383;
		u = ((quad & 64'sd1) != 0) ? (64'sd16384 - r) : r;
		x = u <<< 16;
		x2 = rnd_asr(x * x, 30);
		acc = COEF_A9;
		acc = COEF_A7 + rnd_asr(acc * x2, 30);
		acc = COEF_A5 + rnd_asr(acc * x2, 30);
		acc = COEF_A3 + rnd_asr(acc * x2, 30);
		acc = COEF_A1 + rnd_asr(acc * x2, 30);
		mag = rnd_asr(acc * x, 45);
		if (mag < 0) mag = 0;
		if (mag > 32767) mag = 32767;
		if ((quad & 64'sd2) != 0) mag = -mag;
		return 16'(mag);
	endfunction

	function automatic sine_rom_t build_sine_rom();
		sine_rom_t t;
		for (int k = 0; k < SINE_TABLE_DEPTH; k++) begin
			t[k] = sine_entry(k);
		end
		return t;
	endfunction

	localparam sine_rom_t SINE_ROM = build_sine_rom();

endpackage

`default_nettype wire

// ===== src/foc_current_loop_unit.sv =====
// A sample word is worked through on the shared 4-bit digit-serial
// multiplier (13 products of 5 digit steps each, plus table reads and
// rounding steps); sample_stall holds off the next word until the volt
// word of the last one is loaded.
// Reset: integrators clear to zero, gains and limit take their reset values.
// ---------------------------------------------------------------------------
// foc_current_loop_unit
// Clarke/Park transforms, d/q PI regulators and inverse Park, sequenced
// over one serial multiplier.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module foc_current_loop_unit (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               sample_valid,
	output logic                                    sample_stall,
	input  wire fclu_pkg::sample_t                  sample,
	output logic                                    volt_valid,
	input  wire logic                               volt_stall,
	output fclu_pkg::volt_t                         volt,
	input  wire logic                               psel,
	input  wire logic                               penable,
	input  wire logic                               pwrite,
	input  wire logic [fclu_pkg::PADDR_W-1:0]       paddr,
	input  wire logic [31:0]                        pwdata,
	output logic [31:0]                             prdata,
	output logic                                    pready
);
	import fclu_pkg::*;

	state_t state_q;
	state_t state_d;
	op_t    op_q;

	logic [15:0] prop_gain_q;
	logic [15:0] integ_gain_q;
	logic [14:0] limit_q;

	sample_t smp_q;
	logic signed [15:0] sin_q;
	logic signed [15:0] cos_q;
	logic signed [15:0] beta_q;
	logic signed [15:0] id_q;
	logic signed [15:0] iq_q;
	logic signed [15:0] vd_q;
	logic signed [15:0] vq_q;
	logic signed [15:0] va_q;
	logic signed [15:0] integ_d_q;
	logic signed [15:0] integ_q_q;
	logic signed [ACC_W-1:0] acc_q;
	volt_t volt_q;
	logic  volt_valid_q;

	logic mul_start;
	logic mul_done;
	logic out_load;
	logic rom_cos_sel;
	logic signed [MUL_W-1:0]  a_op;
	logic signed [MUL_W-1:0]  b_op;
	logic signed [PROD_W-1:0] mul_product;
	acc_mode_t acc_mode;
	fin_t fin;

	logic [SINE_IDX_W-1:0] sin_idx;
	logic [SINE_IDX_W-1:0] cos_idx;
	logic [SINE_IDX_W-1:0] rom_addr;
	logic [SINE_IDX_W:0]   cos_sum;
	logic [31:0]           k_full;
	logic signed [15:0]    rom_data;

	logic signed [16:0] err_d;
	logic signed [16:0] err_q;
	logic signed [17:0] ab_sum;
	logic signed [ACC_W-1:0] r16;
	logic signed [ACC_W-1:0] r15;
	logic signed [ACC_W-1:0] r8;
	logic cfg_wr;
	reg_idx_t cfg_idx;

	function automatic logic signed [15:0] sat16(logic signed [ACC_W-1:0] v);
		if (v > 40'sd32767) return 16'sh7fff;
		if (v < -40'sd32768) return 16'sh8000;
		return v[15:0];
	endfunction

	function automatic logic signed [15:0] clamp_sym(logic signed [ACC_W-1:0] v,
			logic [14:0] lim);
		logic signed [ACC_W-1:0] l;
		l = ACC_W'(signed'({1'b0, lim}));
		if (v > l) return 16'(l);
		if (v < -l) return 16'(-l);
		return v[15:0];
	endfunction

	// ---------------- configuration port ----------------
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;
	assign cfg_idx = reg_idx_t'(paddr[3:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prop_gain_q  <= 16'd512;
			integ_gain_q <= 16'd655;
			limit_q      <= 15'd20480;
		end else if (cfg_wr) begin
			unique case (cfg_idx)
				REG_PROP_GAIN:  prop_gain_q  <= pwdata[15:0];
				REG_INTEG_GAIN: integ_gain_q <= pwdata[15:0];
				REG_LIMIT:      limit_q      <= pwdata[14:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (cfg_idx)
			REG_PROP_GAIN:  prdata = {16'd0, prop_gain_q};
			REG_INTEG_GAIN: prdata = {16'd0, integ_gain_q};
			REG_LIMIT:      prdata = {17'd0, limit_q};
			default:        prdata = '0;
		endcase
	end

	// ---------------- table addressing ----------------
	always_comb begin
		k_full = (32'(smp_q.angle) * 32'(SINE_TABLE_DEPTH)) >> 16;
		if (k_full >= 32'(SINE_TABLE_DEPTH)) begin
			sin_idx = SINE_IDX_W'(SINE_TABLE_DEPTH - 1);
		end else begin
			sin_idx = k_full[SINE_IDX_W-1:0];
		end
		cos_sum = (SINE_IDX_W + 1)'(sin_idx) + (SINE_IDX_W + 1)'(SINE_QUARTER);
		if (cos_sum >= (SINE_IDX_W + 1)'(SINE_TABLE_DEPTH)) begin
			cos_sum = cos_sum - (SINE_IDX_W + 1)'(SINE_TABLE_DEPTH);
		end
		cos_idx = cos_sum[SINE_IDX_W-1:0];
		rom_addr = rom_cos_sel ? cos_idx : sin_idx;
	end

	fclu_sine_rom u_rom (
		.clk  (clk),
		.addr (rom_addr),
		.data (rom_data)
	);

	// ---------------- operand selection ----------------
	assign err_d = 17'(smp_q.target_d) - 17'(id_q);
	assign err_q = 17'(smp_q.target_q) - 17'(iq_q);
	assign ab_sum = 18'(smp_q.current_a) + (18'(smp_q.current_b) <<< 1);

	always_comb begin
		a_op = '0;
		b_op = '0;
		acc_mode = ACC_LOAD;
		fin = FIN_NONE;
		unique case (op_q)
			OP_BETA: begin
				a_op = ab_sum; b_op = INV_SQRT3_Q16; fin = FIN_BETA;
			end
			OP_ID_C: begin
				a_op = 18'(smp_q.current_a); b_op = 18'(cos_q);
			end
			OP_ID_S: begin
				a_op = 18'(beta_q); b_op = 18'(sin_q); acc_mode = ACC_ADD; fin = FIN_ID;
			end
			OP_IQ_C: begin
				a_op = 18'(beta_q); b_op = 18'(cos_q);
			end
			OP_IQ_S: begin
				a_op = 18'(smp_q.current_a); b_op = 18'(sin_q);
				acc_mode = ACC_SUB; fin = FIN_IQ;
			end
			OP_INTD: begin
				a_op = 18'(err_d); b_op = {2'b00, integ_gain_q}; fin = FIN_INTD;
			end
			OP_VD: begin
				a_op = 18'(err_d); b_op = {2'b00, prop_gain_q}; fin = FIN_VD;
			end
			OP_INTQ: begin
				a_op = 18'(err_q); b_op = {2'b00, integ_gain_q}; fin = FIN_INTQ;
			end
			OP_VQ: begin
				a_op = 18'(err_q); b_op = {2'b00, prop_gain_q}; fin = FIN_VQ;
			end
			OP_VA_C: begin
				a_op = 18'(vd_q); b_op = 18'(cos_q);
			end
			OP_VA_S: begin
				a_op = 18'(vq_q); b_op = 18'(sin_q); acc_mode = ACC_SUB; fin = FIN_VA;
			end
			OP_VB_S: begin
				a_op = 18'(vd_q); b_op = 18'(sin_q);
			end
			OP_VB_C: begin
				a_op = 18'(vq_q); b_op = 18'(cos_q); acc_mode = ACC_ADD; fin = FIN_VB;
			end
			default: ;
		endcase
	end

	fclu_serial_mul u_mul (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (mul_start),
		.a       (a_op),
		.b       (b_op),
		.done    (mul_done),
		.product (mul_product)
	);

	// ---------------- sequencer ----------------
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:      if (sample_valid) state_d = ST_ROM_SIN;
			ST_ROM_SIN:   state_d = ST_ROM_COS;
			ST_ROM_COS:   state_d = ST_ROM_LAST;
			ST_ROM_LAST:  state_d = ST_MUL_START;
			ST_MUL_START: state_d = ST_MUL_WAIT;
			ST_MUL_WAIT: begin
				if (mul_done) state_d = (fin != FIN_NONE) ? ST_FIN : ST_MUL_START;
			end
			ST_FIN:       state_d = (op_q == OP_VB_C) ? ST_OUT : ST_MUL_START;
			ST_OUT:       if (!volt_valid_q || !volt_stall) state_d = ST_IDLE;
			default:      state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		sample_stall = (state_q != ST_IDLE);
		mul_start = (state_q == ST_MUL_START);
		rom_cos_sel = (state_q == ST_ROM_COS);
		out_load = (state_q == ST_OUT) && (!volt_valid_q || !volt_stall);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			op_q <= OP_BETA;
			volt_valid_q <= 1'b0;
			integ_d_q <= '0;
			integ_q_q <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_IDLE) begin
				op_q <= OP_BETA;
			end else if ((state_q == ST_MUL_WAIT && mul_done && fin == FIN_NONE) ||
					(state_q == ST_FIN && op_q != OP_VB_C)) begin
				op_q <= op_t'(op_q + 4'd1);
			end
			if (out_load) begin
				volt_valid_q <= 1'b1;
			end else if (!volt_stall) begin
				volt_valid_q <= 1'b0;
			end
			if (state_q == ST_FIN) begin
				if (fin == FIN_INTD) integ_d_q <= clamp_sym(ACC_W'(integ_d_q) + r16, limit_q);
				if (fin == FIN_INTQ) integ_q_q <= clamp_sym(ACC_W'(integ_q_q) + r16, limit_q);
			end
		end
	end

	// round half up at each scaling point
	assign r16 = (acc_q + 40'sd32768) >>> 16;
	assign r15 = (acc_q + 40'sd16384) >>> 15;
	assign r8  = (acc_q + 40'sd128) >>> 8;

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && sample_valid) smp_q <= sample;
		if (state_q == ST_ROM_COS) sin_q <= rom_data;
		if (state_q == ST_ROM_LAST) cos_q <= rom_data;
		if (state_q == ST_MUL_WAIT && mul_done) begin
			unique case (acc_mode)
				ACC_LOAD: acc_q <= ACC_W'(mul_product);
				ACC_ADD:  acc_q <= acc_q + ACC_W'(mul_product);
				ACC_SUB:  acc_q <= acc_q - ACC_W'(mul_product);
				default:  acc_q <= acc_q;
			endcase
		end
		if (state_q == ST_FIN) begin
			unique case (fin)
				FIN_BETA: beta_q <= sat16(r16);
				FIN_ID:   id_q <= sat16(r15);
				FIN_IQ:   iq_q <= sat16(r15);
				FIN_VD:   vd_q <= clamp_sym(r8 + ACC_W'(integ_d_q), limit_q);
				FIN_VQ:   vq_q <= clamp_sym(r8 + ACC_W'(integ_q_q), limit_q);
				FIN_VA:   va_q <= sat16(r15);
				default: ;
			endcase
		end
		// acc still holds the beta sum while the word waits in ST_OUT
		if (out_load) begin
			volt_q.volt_alpha <= va_q;
			volt_q.volt_beta  <= sat16(r15);
		end
	end

	assign volt_valid = volt_valid_q;
	assign volt = volt_q;

endmodule

`default_nettype wire

// ===== src/fclu_sine_rom.sv =====
// ---------------------------------------------------------------------------
// fclu_sine_rom
// Full-wave Q15 sine table with a registered read port.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module fclu_sine_rom (
	input  wire logic                             clk,
	input  wire logic [fclu_pkg::SINE_IDX_W-1:0]  addr,
	output logic signed [15:0]                    data
);
	import fclu_pkg::*;

	logic signed [15:0] data_q;

	always_ff @(posedge clk) begin
		data_q <= SINE_ROM[addr];
	end

	assign data = data_q;

endmodule

`default_nettype wire

// ===== src/fclu_serial_mul.sv =====
// ---------------------------------------------------------------------------
// fclu_serial_mul
// Signed 18x18 multiplier taking the second operand four bits per cycle.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module fclu_serial_mul (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                start,
	input  wire logic signed [fclu_pkg::MUL_W-1:0]   a,
	input  wire logic signed [fclu_pkg::MUL_W-1:0]   b,
	output logic                                     done,
	output logic signed [fclu_pkg::PROD_W-1:0]       product
);
	import fclu_pkg::*;

	localparam int LO_W = DIGIT_W * MUL_DIGITS;
	localparam int SUM_W = MUL_W + DIGIT_W + 1;
	localparam int HI_W = SUM_W - DIGIT_W;
	localparam int CNT_W = $clog2(MUL_DIGITS);

	logic signed [MUL_W-1:0] a_q;
	logic signed [HI_W-1:0]  hi_q;
	logic [LO_W-1:0]         lo_q;
	logic [CNT_W-1:0]        cnt_q;
	logic                    busy_q;
	logic                    done_q;

	logic                    last;
	logic [DIGIT_W-1:0]      digit;
	logic signed [SUM_W-1:0] a_x;
	logic signed [SUM_W-1:0] d_x;
	logic signed [SUM_W-1:0] sum;
	logic [HI_W+LO_W-1:0]    full;

	assign last = (cnt_q == CNT_W'(MUL_DIGITS - 1));
	assign digit = lo_q[DIGIT_W-1:0];

	always_comb begin
		a_x = SUM_W'(a_q);
		// top digit carries the sign of the second operand
		d_x = {{(SUM_W - DIGIT_W){last & digit[DIGIT_W-1]}}, digit};
		sum = SUM_W'(hi_q) + SUM_W'(a_x * d_x);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + CNT_W'(1);
				if (last) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q  <= a;
			hi_q <= '0;
			lo_q <= LO_W'(b);
		end else if (busy_q) begin
			hi_q <= HI_W'(sum >>> DIGIT_W);
			lo_q <= {sum[DIGIT_W-1:0], lo_q[LO_W-1:DIGIT_W]};
		end
	end

	assign full = {hi_q, lo_q};
	assign product = full[PROD_W-1:0];
	assign done = done_q;

endmodule

`default_nettype wire

// ===== src/fclu_checker.sv =====
// ---------------------------------------------------------------------------
// fclu_checker
// Port-level checks of the FOC current loop unit, bound to the top level.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "foc_current_loop_unit_defines.svh"

module fclu_checker (
	input wire logic              clk,
	input wire logic              arst_n,
	input wire logic              sample_valid,
	input wire logic              sample_stall,
	input wire logic              volt_valid,
	input wire logic              volt_stall,
	input wire fclu_pkg::volt_t   volt
);
	import fclu_pkg::*;

	`FCLU_ASSERT_NEXT(a_volt_hold, volt_valid && volt_stall, volt_valid, "volt word dropped")
	`FCLU_ASSERT_NEXT(a_volt_stable, volt_valid && volt_stall, $stable(volt), "volt word changed")
	`FCLU_ASSERT_NEXT(a_busy_after_accept, sample_valid && !sample_stall, sample_stall, "second word taken")
	`FCLU_ASSERT_NEXT(a_no_early_result, sample_valid && !sample_stall, !$rose(volt_valid), "result too early")

endmodule

bind foc_current_loop_unit fclu_checker u_fclu_checker (.*);

`default_nettype wire
